@@ sv/rlpe_pkg.sv @@
// Shared types, constants and the gamma curve of the RGB LED chain pulse encoder.
package rlpe_pkg;

  localparam int unsigned LED_COUNT    = 64;
  localparam int unsigned BITS_PER_LED = 24;
  localparam int unsigned LED_AW       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned SLOT_W       = $clog2(LED_COUNT + 1);
  localparam int unsigned BIT_W        = $clog2(BITS_PER_LED);
  localparam int unsigned COLOR_W      = 24;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned GAP_W        = 10;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET_ONE = 2'd1,
    OP_SET_ALL = 2'd2,
    OP_ALL_OFF = 2'd3
  } rlpe_op_e;

  typedef enum logic [1:0] {
    REG_BIT_PERIOD    = 2'd0,
    REG_ZERO_HIGH     = 2'd1,
    REG_ONE_HIGH      = 2'd2,
    REG_RESET_PERIODS = 2'd3
  } rlpe_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC,
    ST_WRITE,
    ST_READ,
    ST_EMIT
  } rlpe_state_e;

  typedef struct packed {
    rlpe_op_e           opcode;
    logic [7:0]         led_index;
    logic [COLOR_W-1:0] color;
  } rlpe_in_t;

  typedef struct packed {
    logic               line_level;
    logic [COLOR_W-1:0] read_color;
    logic               frame_start;
  } rlpe_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] bit_period;
    logic [CFG_W-1:0] zero_high;
    logic [CFG_W-1:0] one_high;
    logic [GAP_W-1:0] reset_periods;
  } rlpe_cfg_t;

  typedef struct packed {
    logic line_level;
    logic frame_start;
  } rlpe_line_t;

  // Entry i is 255*(i/255)^(20/9), rounded. The rounding test is exact:
  // the result reaches k when i^20 * 2^9 > (2k-1)^9 * 255^11.
  function automatic logic [2047:0] gamma_build();
    logic [191:0]  lhs;
    logic [191:0]  rhs;
    logic [191:0]  k255;
    logic [2047:0] tab;
    int unsigned   v;
    logic          go;
    tab  = '0;
    v    = 0;
    k255 = 192'd1;
    for (int n = 0; n < 11; n++) k255 = k255 * 192'd255;
    for (int i = 0; i < 256; i++) begin
      lhs = 192'd1;
      for (int n = 0; n < 20; n++) lhs = lhs * 192'(i);
      lhs = lhs << 9;
      go  = 1'b1;
      while (go && (v < 255)) begin
        rhs = 192'd1;
        for (int n = 0; n < 9; n++) rhs = rhs * 192'(2 * v + 1);
        rhs = rhs * k255;
        if (lhs > rhs) begin
          v = v + 1;
        end else begin
          go = 1'b0;
        end
      end
      tab[i*8 +: 8] = 8'(v);
    end
    return tab;
  endfunction

  localparam logic [2047:0] GAMMA_CURVE = gamma_build();

  function automatic logic [7:0] gamma_lookup(logic [7:0] x);
    return GAMMA_CURVE[{x, 3'b000} +: 8];
  endfunction

endpackage

@@ sv/rlpe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rlpe_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 24,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/rlpe_gamma.sv @@
// Byte-serial gamma encoder: turns 0xRRGGBB into corrected GRB, one byte per cycle.
module rlpe_gamma (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rlpe_pkg::COLOR_W-1:0]  color_i,
  output logic                          last_o,
  output logic [rlpe_pkg::COLOR_W-1:0]  enc_o
);
  import rlpe_pkg::*;

  logic [COLOR_W-1:0] src_q, src_d;
  logic [COLOR_W-1:0] enc_q, enc_d;
  logic [1:0]         cnt_q, cnt_d;

  always_comb begin
    src_d = src_q;
    enc_d = enc_q;
    cnt_d = cnt_q;
    if (start_i) begin
      // Reorder to G, R, B so that the bytes come out in line order.
      src_d = {color_i[15:8], color_i[23:16], color_i[7:0]};
      cnt_d = 2'd3;
    end else if (cnt_q != 2'd0) begin
      enc_d = {enc_q[15:0], gamma_lookup(src_q[23:16])};
      src_d = {src_q[15:0], 8'h00};
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    enc_q <= enc_d;
  end

  assign last_o = (cnt_q == 2'd1);
  assign enc_o  = enc_q;

endmodule

@@ sv/rlpe_timing.sv @@
// Bit, slot and gap timing with the serial shift register of the line waveform.
module rlpe_timing (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  rlpe_pkg::rlpe_cfg_t           cfg_i,
  input  logic [rlpe_pkg::COLOR_W-1:0]  word_i,
  output logic [rlpe_pkg::SLOT_W-1:0]   slot_o,
  output rlpe_pkg::rlpe_line_t          status_o
);
  import rlpe_pkg::*;

  localparam logic [BIT_W-1:0] LastBit = BIT_W'(BITS_PER_LED - 1);

  logic [CFG_W-1:0]   tick_q, tick_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [GAP_W-1:0]   gap_q, gap_d;
  logic               gap_on_q, gap_on_d;
  logic [COLOR_W-1:0] word_q, word_d;
  logic               load;
  logic [COLOR_W-1:0] cur_word;
  logic [CFG_W-1:0]   high;
  logic [GAP_W-1:0]   gap_inc;

  always_comb begin
    // A new slot word is taken on the first tick of its first bit.
    load     = !gap_on_q && (tick_q == '0) && (bit_q == '0);
    cur_word = load ? word_i : word_q;
    high     = cur_word[COLOR_W-1] ? cfg_i.one_high : cfg_i.zero_high;
    status_o.line_level  = !gap_on_q && (tick_q < high);
    status_o.frame_start = load && (slot_q == '0);

    gap_inc  = gap_q + GAP_W'(1);
    tick_d   = tick_q;
    bit_d    = bit_q;
    slot_d   = slot_q;
    gap_d    = gap_q;
    gap_on_d = gap_on_q;
    word_d   = word_q;
    if (step_i) begin
      word_d = cur_word;
      if (tick_q >= cfg_i.bit_period) begin
        tick_d = '0;
        if (gap_on_q) begin
          if (gap_inc >= cfg_i.reset_periods) begin
            gap_on_d = 1'b0;
            gap_d    = '0;
            slot_d   = '0;
            bit_d    = '0;
          end else begin
            gap_d = gap_inc;
          end
        end else begin
          word_d = {cur_word[COLOR_W-2:0], 1'b0};
          if (bit_q == LastBit) begin
            bit_d = '0;
            if (slot_q == SLOT_W'(LED_COUNT)) begin
              slot_d   = '0;
              gap_d    = '0;
              gap_on_d = (cfg_i.reset_periods != '0);
            end else begin
              slot_d = slot_q + SLOT_W'(1);
            end
          end else begin
            bit_d = bit_q + BIT_W'(1);
          end
        end
      end else begin
        tick_d = tick_q + CFG_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      bit_q    <= '0;
      slot_q   <= '0;
      gap_q    <= '0;
      gap_on_q <= 1'b0;
      word_q   <= '0;
    end else begin
      tick_q   <= tick_d;
      bit_q    <= bit_d;
      slot_q   <= slot_d;
      gap_q    <= gap_d;
      gap_on_q <= gap_on_d;
      word_q   <= word_d;
    end
  end

  assign slot_o = slot_q;

endmodule

@@ sv/rgb_led_chain_pulse_encoder.sv @@
// Top level of the RGB LED chain pulse encoder: command sequencing, color stores, output register.
// Usage:
// Each input transaction is one timer tick carrying a command (tick only, set one LED,
// set all LEDs, all off), an LED index and a raw 0xRRGGBB color. Each one yields
// exactly one output transaction: the line level for that tick, the raw color of the
// indexed LED after the command (0 when out of range) and a frame start flag.
// A tick passes through the read and emit states; all off passes the write state first,
// and set one or set all also wait in the encode state for the byte-serial gamma encoder.
// The input is taken again in the cycle after the result is registered; the sequencer
// handles one item at a time.
// Set all and all off finish in the write state: they replace a fill color and clear
// the per-LED written flags, so no sweep of the color RAMs is needed.
// A finished result waits in the output register; a new item is accepted meanwhile,
// and its result is held back until the receiver takes the older one.
// Reset returns the timing to the start of a frame, restores the default register values
// and makes every LED read as black; there is no clearing pass. Registers are written
// through the plain write port; the user must do so only while the block is idle (unenforced).
module rgb_led_chain_pulse_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  rlpe_pkg::rlpe_reg_e           cfg_index_i,
  input  logic [rlpe_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rlpe_pkg::rlpe_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rlpe_pkg::rlpe_out_t           out_data_o
);
  import rlpe_pkg::*;

  rlpe_state_e        state_q, state_d;
  rlpe_cfg_t          cfg_q;
  rlpe_op_e           op_q;
  logic [7:0]         idx_q;
  logic [COLOR_W-1:0] color_q;
  logic [LED_COUNT-1:0] vld_q;
  logic [COLOR_W-1:0] fill_raw_q;
  logic [COLOR_W-1:0] fill_enc_q;
  logic               out_valid_q;
  rlpe_out_t          out_data_q;

  logic               in_fire;
  logic               idx_ok;
  logic               slot_ok;
  logic               ram_we;
  logic               enc_start;
  logic               enc_last;
  logic [COLOR_W-1:0] enc_word;
  logic [COLOR_W-1:0] raw_rdata;
  logic [COLOR_W-1:0] enc_rdata;
  logic [COLOR_W-1:0] rd_color;
  logic [COLOR_W-1:0] slot_word;
  logic [SLOT_W-1:0]  slot;
  logic               step;
  logic               out_free;
  rlpe_line_t         line;

  assign in_fire  = in_valid_i && in_ready_o;
  assign idx_ok   = ({1'b0, idx_q} < 9'(LED_COUNT));
  assign slot_ok  = (slot < SLOT_W'(LED_COUNT));
  assign out_free = !out_valid_q || out_ready_i;

  // Config register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period    <= CFG_W'(89);
      cfg_q.zero_high     <= CFG_W'(28);
      cfg_q.one_high      <= CFG_W'(56);
      cfg_q.reset_periods <= GAP_W'(50);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BIT_PERIOD:    cfg_q.bit_period    <= cfg_data_i;
        REG_ZERO_HIGH:     cfg_q.zero_high     <= cfg_data_i;
        REG_ONE_HIGH:      cfg_q.one_high      <= cfg_data_i;
        REG_RESET_PERIODS: cfg_q.reset_periods <= cfg_data_i[GAP_W-1:0];
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    enc_start  = 1'b0;
    ram_we     = 1'b0;
    step       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_data_i.opcode) inside
            OP_SET_ONE, OP_SET_ALL: begin
              enc_start = 1'b1;
              state_d   = ST_ENC;
            end
            OP_ALL_OFF: state_d = ST_WRITE;
            default:    state_d = ST_READ;
          endcase
        end
      end
      ST_ENC: begin
        if (enc_last) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_we  = (op_q == OP_SET_ONE) && idx_ok;
        state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          step    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= in_data_i.opcode;
      idx_q   <= in_data_i.led_index;
      color_q <= in_data_i.color;
    end
  end

  // An LED not written since the last bulk command reads as the fill color.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      fill_raw_q <= '0;
      fill_enc_q <= '0;
    end else if (state_q == ST_WRITE) begin
      if (ram_we) begin
        vld_q[idx_q[LED_AW-1:0]] <= 1'b1;
      end else if (op_q == OP_SET_ALL) begin
        vld_q      <= '0;
        fill_raw_q <= color_q;
        fill_enc_q <= enc_word;
      end else if (op_q == OP_ALL_OFF) begin
        vld_q      <= '0;
        fill_raw_q <= '0;
        fill_enc_q <= '0;
      end
    end
  end

  rlpe_gamma u_gamma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (enc_start),
    .color_i (in_data_i.color),
    .last_o  (enc_last),
    .enc_o   (enc_word)
  );

  rlpe_ram #(
    .Depth (LED_COUNT),
    .Width (COLOR_W)
  ) u_raw_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[LED_AW-1:0]),
    .wdata_i (color_q),
    .raddr_i (idx_q[LED_AW-1:0]),
    .rdata_o (raw_rdata)
  );

  rlpe_ram #(
    .Depth (LED_COUNT),
    .Width (COLOR_W)
  ) u_enc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[LED_AW-1:0]),
    .wdata_i (enc_word),
    .raddr_i (slot[LED_AW-1:0]),
    .rdata_o (enc_rdata)
  );

  always_comb begin
    rd_color  = '0;
    slot_word = '0;
    if (idx_ok) begin
      rd_color = vld_q[idx_q[LED_AW-1:0]] ? raw_rdata : fill_raw_q;
    end
    if (slot_ok) begin
      slot_word = vld_q[slot[LED_AW-1:0]] ? enc_rdata : fill_enc_q;
    end
  end

  rlpe_timing u_timing (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg_q),
    .word_i   (slot_word),
    .slot_o   (slot),
    .status_o (line)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q.line_level  <= line.line_level;
      out_data_q.read_color  <= rd_color;
      out_data_q.frame_start <= line.frame_start;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ dv/tb_rgb_led_chain_pulse_encoder.sv @@
// Self-checking testbench for the RGB LED chain pulse encoder: line waveform, readback, frames.
`timescale 1ns / 100ps

module tb_rgb_led_chain_pulse_encoder;
  import rlpe_pkg::*;

  typedef struct {
    rlpe_in_t  item;
    bit        typed;
    rlpe_out_t want;
  } directed_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  rlpe_reg_e            cfg_index_i = REG_BIT_PERIOD;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  rlpe_in_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  rlpe_out_t            out_data_o;

  // Predictor state: color stores, gamma table, frame timing and register copies.
  logic [7:0]           gamma_lut [256];
  logic [COLOR_W-1:0]   raw_col [LED_COUNT];
  logic [COLOR_W-1:0]   grb_col [LED_COUNT];
  logic [15:0]          bit_tick;
  logic [4:0]           bit_idx;
  logic [6:0]           slot_idx;
  logic [GAP_W-1:0]     gap_cnt;
  logic                 gap_on;
  logic [COLOR_W-1:0]   sent_word;
  logic [CFG_W-1:0]     cfg_period, cfg_zero_hi, cfg_one_hi;
  logic [GAP_W-1:0]     cfg_gap;

  rlpe_out_t            pending_ticks [$];
  directed_row_t        directed_rows [$];
  int unsigned          items_sent = 0;
  int unsigned          mismatches = 0;
  bit                   steady = 1'b0;

  rgb_led_chain_pulse_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // True when 255*(x/255)^(20/9) is above k-1/2, decided exactly on wide integers.
  function automatic bit rounds_to_at_least(int unsigned x, int unsigned k);
    logic [199:0] lhs;
    logic [199:0] rhs;
    lhs = 200'd512;
    rhs = 200'd1;
    for (int n = 0; n < 20; n++) lhs = lhs * x;
    for (int n = 0; n < 9; n++) rhs = rhs * (2 * k - 1);
    for (int n = 0; n < 11; n++) rhs = rhs * 255;
    return lhs > rhs;
  endfunction

  // A floating-point estimate, then nudged until the exact rounding test agrees.
  function automatic void build_gamma_lut();
    real est;
    int  c;
    for (int i = 0; i < 256; i++) begin
      est = 255.0 * $pow(i / 255.0, 20.0 / 9.0);
      c = $rtoi(est + 0.5);
      if (c > 255) c = 255;
      while ((c < 255) && rounds_to_at_least(i, c + 1)) c++;
      while ((c > 0) && !rounds_to_at_least(i, c)) c--;
      gamma_lut[i] = 8'(c);
    end
  endfunction

  // Raw 0xRRGGBB in, gamma-corrected word in line order (green, red, blue) out.
  function automatic logic [COLOR_W-1:0] gamma_grb(logic [COLOR_W-1:0] c);
    return {gamma_lut[c[15:8]], gamma_lut[c[23:16]], gamma_lut[c[7:0]]};
  endfunction

  // One timer tick: apply the command, produce this tick's line level, advance the timing.
  function automatic rlpe_out_t predict_tick(rlpe_in_t item);
    rlpe_out_t          res;
    logic [COLOR_W-1:0] enc;
    logic [15:0]        hi_ticks;
    res = '0;
    case (item.opcode)
      OP_SET_ONE: begin
        if (item.led_index < LED_COUNT) begin
          raw_col[item.led_index[LED_AW-1:0]] = item.color;
          grb_col[item.led_index[LED_AW-1:0]] = gamma_grb(item.color);
        end
      end
      OP_SET_ALL: begin
        enc = gamma_grb(item.color);
        for (int k = 0; k < LED_COUNT; k++) begin
          raw_col[k] = item.color;
          grb_col[k] = enc;
        end
      end
      OP_ALL_OFF: begin
        for (int k = 0; k < LED_COUNT; k++) begin
          raw_col[k] = '0;
          grb_col[k] = '0;
        end
      end
      default: ;
    endcase
    if (item.led_index < LED_COUNT) res.read_color = raw_col[item.led_index[LED_AW-1:0]];

    if (!gap_on) begin
      // The slot word is latched on the first tick of the slot, after this tick's write.
      if ((bit_tick == 0) && (bit_idx == 0)) begin
        sent_word = (slot_idx < LED_COUNT) ? grb_col[slot_idx[LED_AW-1:0]] : '0;
        if (slot_idx == 0) begin
          res.frame_start = 1'b1;
        end
      end
      hi_ticks = sent_word[BITS_PER_LED - 1 - bit_idx] ? cfg_one_hi : cfg_zero_hi;
      res.line_level = (bit_tick < hi_ticks);
    end

    if (bit_tick >= cfg_period) begin
      bit_tick = '0;
      if (gap_on) begin
        gap_cnt = gap_cnt + 1'b1;
        if (gap_cnt >= cfg_gap) begin
          gap_on   = 1'b0;
          gap_cnt  = '0;
          slot_idx = '0;
          bit_idx  = '0;
        end
      end else begin
        bit_idx++;
        if (bit_idx >= BITS_PER_LED) begin
          bit_idx = '0;
          slot_idx++;
          if (slot_idx > LED_COUNT) begin
            slot_idx = '0;
            gap_cnt  = '0;
            gap_on   = (cfg_gap != 0);
          end
        end
      end
    end else begin
      bit_tick = bit_tick + 1'b1;
    end
    return res;
  endfunction

  function automatic rlpe_in_t random_tick();
    rlpe_in_t    t;
    int unsigned pick;
    logic [2:0]  sel;
    pick = $urandom_range(99);
    if (pick < 50) t.opcode = OP_TICK;
    else if (pick < 82) t.opcode = OP_SET_ONE;
    else if (pick < 92) t.opcode = OP_SET_ALL;
    else t.opcode = OP_ALL_OFF;
    pick = $urandom_range(99);
    // Aim a good share of writes at the slot being sent or the next one.
    if (pick < 35) t.led_index = 8'(slot_idx + $urandom_range(1));
    else if (pick < 75) t.led_index = 8'($urandom_range(LED_COUNT - 1));
    else if (pick < 80) t.led_index = 8'hFF;
    else if (pick < 85) t.led_index = 8'(LED_COUNT);
    else t.led_index = 8'($urandom_range(255));
    pick = $urandom_range(99);
    sel  = 3'($urandom());
    if (pick < 8) t.color = '0;
    else if (pick < 16) t.color = '1;
    else if (pick < 30) t.color = {{8{sel[2]}}, {8{sel[1]}}, {8{sel[0]}}};
    else t.color = 24'($urandom());
    return t;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic add_row(input rlpe_op_e op, input logic [7:0] idx, input logic [23:0] color,
                         input bit typed, input logic level, input logic [23:0] rd,
                         input logic fs);
    directed_row_t row;
    row.item.opcode      = op;
    row.item.led_index   = idx;
    row.item.color       = color;
    row.typed            = typed;
    row.want.line_level  = level;
    row.want.read_color  = rd;
    row.want.frame_start = fs;
    directed_rows.push_back(row);
  endtask

  // Offers one tick command, holds it until the block takes it, and books its result.
  task automatic send_item(input rlpe_in_t item, input bit typed, input rlpe_out_t typed_want);
    rlpe_out_t predicted;
    steady = (items_sent >= 400) && (items_sent < 900);
    while (!steady && ($urandom_range(99) < 22)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = predict_tick(item);
    pending_ticks.push_back(typed ? typed_want : predicted);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input rlpe_reg_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      REG_BIT_PERIOD:    cfg_period  = value;
      REG_ZERO_HIGH:     cfg_zero_hi = value;
      REG_ONE_HIGH:      cfg_one_hi  = value;
      REG_RESET_PERIODS: cfg_gap     = value[GAP_W-1:0];
      default: ;
    endcase
  endtask

  // Reprograms all timing registers while idle, then runs random ticks. A long phase
  // stops halfway until every outstanding result has come back.
  task automatic run_phase(input logic [15:0] period, input logic [15:0] zero_hi,
                           input logic [15:0] one_hi, input logic [9:0] gap,
                           input int unsigned extra);
    drain();
    write_reg(REG_BIT_PERIOD, period);
    write_reg(REG_ZERO_HIGH, zero_hi);
    write_reg(REG_ONE_HIGH, one_hi);
    write_reg(REG_RESET_PERIODS, {6'd0, gap});
    cfg_we_i <= 1'b0;
    for (int n = 0; n < extra; n++) begin
      if ((extra > 100) && (n == extra / 2)) drain();
      send_item(random_tick(), 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin : watch_results
    rlpe_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_ticks.size() == 0) begin
        flag_mismatch("transaction with nothing outstanding", 32'(out_data_o), 32'd0);
      end else begin
        want = pending_ticks.pop_front();
        if (out_data_o.line_level !== want.line_level)
          flag_mismatch("line_level", 32'(out_data_o.line_level), 32'(want.line_level));
        if (out_data_o.read_color !== want.read_color)
          flag_mismatch("read_color", 32'(out_data_o.read_color), 32'(want.read_color));
        if (out_data_o.frame_start !== want.frame_start)
          flag_mismatch("frame_start", 32'(out_data_o.frame_start), 32'(want.frame_start));
      end
    end
    out_ready_i <= steady || ($urandom_range(99) >= 22);
  end

  initial begin
    build_gamma_lut();
    for (int k = 0; k < LED_COUNT; k++) begin
      raw_col[k] = '0;
      grb_col[k] = '0;
    end
    bit_tick    = '0;
    bit_idx     = '0;
    slot_idx    = '0;
    gap_cnt     = '0;
    gap_on      = 1'b0;
    sent_word   = '0;
    cfg_period  = 16'd89;
    cfg_zero_hi = 16'd28;
    cfg_one_hi  = 16'd56;
    cfg_gap     = 10'd50;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset timing: the first 20 ticks all sit inside the high part of a zero bit.
    add_row(OP_TICK,    8'd0,   24'h000000, 1'b1, 1'b1, 24'h000000, 1'b1);
    add_row(OP_TICK,    8'd255, 24'hFFFFFF, 1'b1, 1'b1, 24'h000000, 1'b0);
    add_row(OP_SET_ONE, 8'd0,   24'hFFFFFF, 1'b1, 1'b1, 24'hFFFFFF, 1'b0);
    add_row(OP_SET_ONE, 8'd63,  24'h123456, 1'b1, 1'b1, 24'h123456, 1'b0);
    add_row(OP_SET_ONE, 8'd64,  24'hABCDEF, 1'b1, 1'b1, 24'h000000, 1'b0);
    add_row(OP_SET_ONE, 8'd255, 24'hFFFFFF, 1'b1, 1'b1, 24'h000000, 1'b0);
    add_row(OP_TICK,    8'd63,  24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0);
    add_row(OP_SET_ALL, 8'd200, 24'h800000, 1'b1, 1'b1, 24'h000000, 1'b0);
    add_row(OP_TICK,    8'd5,   24'h000000, 1'b1, 1'b1, 24'h800000, 1'b0);
    add_row(OP_SET_ONE, 8'd5,   24'h000001, 1'b0, 1'b0, 24'h000000, 1'b0);
    add_row(OP_ALL_OFF, 8'd5,   24'hFFFFFF, 1'b1, 1'b1, 24'h000000, 1'b0);
    add_row(OP_TICK,    8'd63,  24'h000000, 1'b1, 1'b1, 24'h000000, 1'b0);
    add_row(OP_SET_ALL, 8'd0,   24'hFFFFFF, 1'b1, 1'b1, 24'hFFFFFF, 1'b0);
    add_row(OP_SET_ALL, 8'd64,  24'h000000, 1'b1, 1'b1, 24'h000000, 1'b0);
    add_row(OP_SET_ONE, 8'd1,   24'h010203, 1'b0, 1'b0, 24'h000000, 1'b0);
    add_row(OP_SET_ONE, 8'd2,   24'hFEFDFC, 1'b0, 1'b0, 24'h000000, 1'b0);
    add_row(OP_ALL_OFF, 8'd255, 24'h000000, 1'b1, 1'b1, 24'h000000, 1'b0);
    add_row(OP_SET_ONE, 8'd0,   24'hA5A5A5, 1'b0, 1'b0, 24'h000000, 1'b0);
    add_row(OP_TICK,    8'd128, 24'h000000, 1'b1, 1'b1, 24'h000000, 1'b0);
    add_row(OP_SET_ALL, 8'd7,   24'h5A5A5A, 1'b0, 1'b0, 24'h000000, 1'b0);
    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
    end

    // Shortest bits first, then extreme high times, then random short settings, then the defaults.
    run_phase(16'd1, 16'd1, 16'd2, 10'd0, 700);
    run_phase(16'd1, 16'd0, 16'hFFFF, 10'd2, 300);
    run_phase(16'hFFFF, 16'hFFFF, 16'd0, 10'h3FF, 60);
    run_phase(16'd3, 16'($urandom_range(5)), 16'($urandom_range(5)), 10'd1, 470);
    run_phase(16'd89, 16'd28, 16'd56, 10'd50, 100);

    drain();
    repeat (10) @(posedge clk_i);
    if ((mismatches == 0) && (pending_ticks.size() == 0)) begin
      $display("tb_rgb_led_chain_pulse_encoder: PASS");
    end else begin
      $display("tb_rgb_led_chain_pulse_encoder: FAIL");
    end
    $finish;
  end

  initial begin
    #(64'd1_000_000 * 10);
    $display("tb_rgb_led_chain_pulse_encoder: FAIL");
    $finish;
  end

endmodule
